/* src/ssb_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sort buffer package
// Shared word width, word type and default capacity of the sort buffer.
// ----------------------------------------------------------------------------
package ssb_pkg;

  // Width of one data word, two's complement.
  localparam int unsigned DATA_W = 32;

  // Default number of words held per batch.
  localparam int unsigned MAX_ENTRIES_DEF = 64;

  typedef logic signed [DATA_W-1:0] data_t;

endpackage

/* src/ssb_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sort buffer channels
// Valid/ready channels for incoming words and for sorted result words.
// ----------------------------------------------------------------------------
interface ssb_in_if;
  logic          valid;
  logic          ready;
  ssb_pkg::data_t value;
  logic          last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

interface ssb_out_if;
  logic           valid;
  logic           ready;
  ssb_pkg::data_t sorted_value;
  logic           last_out;
  logic           overflow;

  modport source (output valid, output sorted_value, output last_out, output overflow,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

/* src/selection_sort_buffer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Selection sort buffer
// Collects a batch of signed words and returns them in ascending order.
// ----------------------------------------------------------------------------
// Usage:
//   Words enter on in_i, one per handshake, with last set on the final word
//   of a batch. Up to MAX_ENTRIES words are stored; any word arriving while
//   the store is full is dropped and the batch is flagged as overflowed, the
//   marked word still closes the batch. Sorted words leave on out_o in
//   ascending order, last_out marks the final one, and overflow is set on
//   every word of a flagged batch.
// Operation:
//   While a batch is collected one word is taken every cycle. Once the last
//   word is in, the block stops accepting. For each result of a batch the
//   single read port of the element memory scans the unsorted tail, a wait
//   state then folds in the last read word, and the result is offered until
//   it is taken; no new word is accepted until the last result has left.
// Reset and stalls:
//   Reset empties the batch and clears the overflow flag; the memory itself
//   is not cleared since only words of the current batch are ever read.
//   A result word is held in registers until out_o.ready is seen, and the
//   scan for the next word starts only after it has been taken.
// ----------------------------------------------------------------------------
module selection_sort_buffer #(
  parameter int unsigned MAX_ENTRIES = ssb_pkg::MAX_ENTRIES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssb_in_if.sink     in_i,
  ssb_out_if.source  out_o
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  // Controller states.
  localparam logic [1:0] ST_LOAD = 2'd0;  // collecting words of a batch
  localparam logic [1:0] ST_SCAN = 2'd1;  // issuing reads over the unsorted tail
  localparam logic [1:0] ST_WAIT = 2'd2;  // last read data is being compared
  localparam logic [1:0] ST_EMIT = 2'd3;  // smallest word offered on the output

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] i_q, i_d;        // position being filled in sorted order
  logic [IDX_W-1:0] j_q, j_d;        // read pointer of the scan
  logic             rd_vld_q, rd_vld_d;
  logic [IDX_W-1:0] rd_idx_q;

  // Running minimum of the scan, where it was found, and the word that sat
  // at position i, which moves into the minimum's old slot.
  ssb_pkg::data_t   min_q, min_d;
  logic [IDX_W-1:0] pick_q, pick_d;
  ssb_pkg::data_t   held_q, held_d;

  // Element memory: one write port, one registered read port.
  ssb_pkg::data_t   mem_q [MAX_ENTRIES];
  ssb_pkg::data_t   rd_data_q;
  logic             rd_en;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ssb_pkg::data_t   wr_data;

  logic ld_acc;
  logic out_acc;
  logic not_full;
  logic last_emit;

  assign in_i.ready  = (state_q == ST_LOAD);
  assign ld_acc      = in_i.valid & in_i.ready;
  assign out_o.valid = (state_q == ST_EMIT);
  assign out_acc     = out_o.valid & out_o.ready;

  assign not_full  = count_q < CNT_W'(MAX_ENTRIES);
  assign last_emit = (CNT_W'(i_q) + CNT_W'(1)) == count_q;

  assign out_o.sorted_value = min_q;
  assign out_o.last_out     = last_emit;
  assign out_o.overflow     = ovf_q;

  // Loading writes at the fill pointer; emitting writes the displaced word
  // back into the slot of the minimum. Reads happen only in the scan state,
  // so a read and a write of the same entry never share a cycle.
  assign rd_en   = (state_q == ST_SCAN);
  assign wr_en   = (ld_acc & not_full) | out_acc;
  assign wr_addr = out_acc ? pick_q : count_q[IDX_W-1:0];
  assign wr_data = out_acc ? held_q : in_i.value;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[j_q];
    end
  end

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    i_d      = i_q;
    j_d      = j_q;
    rd_vld_d = (state_q == ST_SCAN);
    min_d    = min_q;
    pick_d   = pick_q;
    held_d   = held_q;

    // Fold the word returned by the memory into the running minimum. The
    // first word of a scan is the one at position i and seeds everything.
    if (rd_vld_q) begin
      if (rd_idx_q == i_q) begin
        min_d  = rd_data_q;
        pick_d = rd_idx_q;
        held_d = rd_data_q;
      end else if (rd_data_q < min_q) begin
        min_d  = rd_data_q;
        pick_d = rd_idx_q;
      end
    end

    unique case (state_q)
      ST_LOAD: begin
        if (ld_acc) begin
          if (not_full) begin
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            i_d     = '0;
            j_d     = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if ((CNT_W'(j_q) + CNT_W'(1)) == count_q) begin
          state_d = ST_WAIT;
        end else begin
          j_d = j_q + IDX_W'(1);
        end
      end
      ST_WAIT: begin
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_acc) begin
          if (last_emit) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = ST_LOAD;
          end else begin
            i_d     = i_q + IDX_W'(1);
            j_d     = i_q + IDX_W'(1);
            state_d = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      count_q  <= '0;
      ovf_q    <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      ovf_q    <= ovf_d;
      i_q      <= i_d;
      j_q      <= j_d;
      rd_vld_q <= rd_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= j_q;
    min_q    <= min_d;
    pick_q   <= pick_d;
    held_q   <= held_d;
  end

  // A result is only offered for a non-empty batch.
  a_emit_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (count_q != '0))
    else $error("result offered with an empty batch");

  // Taking the final result empties the batch and clears the overflow flag.
  a_batch_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_out) |=> (count_q == '0 && !ovf_q && in_i.ready))
    else $error("batch not closed after final result");

  // The sorted position never runs past the stored words.
  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD) |-> (CNT_W'(i_q) < count_q))
    else $error("sort position beyond batch");

  // Read data is only consumed in the cycle after a read was issued.
  a_read_follows_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> ($past(state_q) == ST_SCAN))
    else $error("read data valid without a read");

  // Words are dropped only once the store is full.
  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == CNT_W'(MAX_ENTRIES)))
    else $error("overflow flagged with room left");

endmodule
